// File: sv/smf_pkg.sv
// ---------------------------------------------------------------------------
// Sliding median filter package
// Shared widths, window constants and the sorter control struct.
// ---------------------------------------------------------------------------
package smf_pkg;

   localparam int WINDOW   = 8;
   localparam int SAMPLE_W = 12;
   localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int MID_LO   = WINDOW / 2 - 1;
   localparam int MID_HI   = WINDOW / 2;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [SLOT_W-1:0]   slot_type;

   localparam slot_type   LAST_SLOT  = slot_type'(WINDOW - 1);
   localparam sample_type SAMPLE_MAX = '1;

   // Control from the sequencer to the sorted list.
   typedef struct packed {
      logic clear;    // refill the list with the largest sample value
      logic insert;   // insert the presented sample this cycle
   } sort_ctrl_type;

endpackage

// File: sv/sliding_median_filter_core.sv
// ---------------------------------------------------------------------------
// Sliding median filter core
// Running median over an even window of 12-bit ADC samples, one channel.
// ---------------------------------------------------------------------------
// Usage:
//   Each item on the req_ channel carries one new ADC sample. It replaces
//   the oldest sample of the window, and one item on the rsp_ channel
//   returns the floor average of the two middle values of the sorted
//   window, which is the median for an even window.
//   The window lives in a small synchronous RAM. After a sample is written,
//   the sequencer sweeps all WINDOW entries through the one read port and
//   inserts each into a sorted list, one entry per cycle. The result is
//   registered in the done state, which follows the sweep and the drain
//   step, and no new item is accepted until that is done; the RAM sweep
//   sets the pace of items, with one full sweep for each one.
//   Reset marks every window entry as empty; an empty entry reads as zero,
//   so the first results include those zeros. The write slot returns to 0.
//   A result waits in the output register while the receiver stalls; the
//   next item is still accepted and processed, and it waits only at the
//   final step until the output register is free.
// ---------------------------------------------------------------------------
module sliding_median_filter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] sample, [15:12] expected zero but ignored
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [11:0] filtered, [15:12] zero
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_DRAIN,
      S_DONE
   } state_type;

   state_type state_ff;
   smf_pkg::slot_type   oldest_ff;
   smf_pkg::slot_type   rd_addr_ff;
   logic                rsp_valid_ff;
   smf_pkg::sample_type rsp_data_ff;

   // Window RAM with one valid bit per entry so that reset empties it at once.
   smf_pkg::sample_type         window_mem [smf_pkg::WINDOW];
   logic [smf_pkg::WINDOW-1:0]  valid_ff;
   smf_pkg::sample_type         rd_data_ff;
   logic                        rd_valid_ff;
   logic                        rd_pend_ff;

   logic                        accept;
   logic                        out_free;
   logic                        sweep;
   smf_pkg::sort_ctrl_type      sort_ctrl;
   smf_pkg::sample_type         sort_sample;
   smf_pkg::sample_type         mid_lo;
   smf_pkg::sample_type         mid_hi;
   logic [smf_pkg::SAMPLE_W:0]  mid_sum;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign sweep      = (state_ff == S_SWEEP);

   // RAM write of the new sample and registered read during the sweep.
   always_ff @(posedge clock) begin
      if (accept) begin
         window_mem[oldest_ff] <= req_tdata[smf_pkg::SAMPLE_W-1:0];
      end
      rd_data_ff  <= window_mem[rd_addr_ff];
      rd_valid_ff <= valid_ff[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         if (accept) begin
            valid_ff[oldest_ff] <= 1'b1;
         end
         rd_pend_ff <= sweep;
      end
   end

   // The list is refilled as the item is taken; each read word is inserted
   // the cycle after its read is issued.
   always_comb begin
      sort_ctrl.clear  = accept;
      sort_ctrl.insert = rd_pend_ff;
      sort_sample      = rd_valid_ff ? rd_data_ff : '0;
   end

   smf_sorter u_sorter (
      .clock  (clock),
      .ctrl   (sort_ctrl),
      .sample (sort_sample),
      .mid_lo (mid_lo),
      .mid_hi (mid_hi)
   );

   assign mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oldest_ff    <= '0;
         rd_addr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  oldest_ff  <= (oldest_ff == smf_pkg::LAST_SLOT) ? '0
                                                                  : oldest_ff + 1'b1;
                  rd_addr_ff <= '0;
                  state_ff   <= S_SWEEP;
               end
            end
            S_SWEEP: begin
               rd_addr_ff <= rd_addr_ff + 1'b1;
               if (rd_addr_ff == smf_pkg::LAST_SLOT) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               // The last read word goes into the list in this cycle.
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= mid_sum[smf_pkg::SAMPLE_W:1];
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - smf_pkg::SAMPLE_W){1'b0}}, rsp_data_ff};

endmodule

// File: sv/smf_sorter.sv
// ---------------------------------------------------------------------------
// Sliding median filter sorted list
// Keeps an ascending list of WINDOW samples, one insertion per cycle.
// ---------------------------------------------------------------------------
module smf_sorter (
   input  logic                  clock,
   input  smf_pkg::sort_ctrl_type ctrl,
   input  smf_pkg::sample_type   sample,
   output smf_pkg::sample_type   mid_lo,
   output smf_pkg::sample_type   mid_hi
);

   smf_pkg::sample_type list_ff [smf_pkg::WINDOW];
   smf_pkg::sample_type list_in [smf_pkg::WINDOW];
   logic [smf_pkg::WINDOW-1:0] greater;

   // The list is always sorted, so the greater flags are monotone: the new
   // sample lands at the first greater entry and the rest shift up by one,
   // dropping the top entry.
   always_comb begin
      for (int i = 0; i < smf_pkg::WINDOW; i++) begin
         greater[i] = list_ff[i] > sample;
      end
      for (int i = 0; i < smf_pkg::WINDOW; i++) begin
         if (ctrl.clear) begin
            list_in[i] = smf_pkg::SAMPLE_MAX;
         end else if (!ctrl.insert || !greater[i]) begin
            list_in[i] = list_ff[i];
         end else if (i == 0) begin
            list_in[i] = sample;
         end else if (!greater[i-1]) begin
            list_in[i] = sample;
         end else begin
            list_in[i] = list_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      list_ff <= list_in;
   end

   assign mid_lo = list_ff[smf_pkg::MID_LO];
   assign mid_hi = list_ff[smf_pkg::MID_HI];

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sliding median filter testbench
// Feeds ADC samples into the core and checks every filtered item against a
// running median predictor. Both sides idle at random. The receiver holds
// off once for a long stretch, and the sender pauses once until every
// expected item has come back.
// ---------------------------------------------------------------------------
module testbench;

   localparam int LATENCY      = smf_pkg::WINDOW + 3;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 3000;
   localparam int RANDOM_ITEMS = 1400;
   localparam int IDLE_PCT     = 27;
   localparam int MAX_PRINTED  = 40;

   // Predicts the filtered value for each accepted sample and checks results
   // in order.
   class median_scoreboard;
      smf_pkg::sample_type window_hist[smf_pkg::WINDOW];
      smf_pkg::slot_type   next_slot;
      smf_pkg::sample_type expected_filtered[$];
      int                  errors;

      function new();
         foreach (window_hist[k]) window_hist[k] = '0;
         next_slot = '0;
         errors    = 0;
      endfunction

      function void take_sample(smf_pkg::sample_type fresh);
         smf_pkg::sample_type        ordered[smf_pkg::WINDOW];
         smf_pkg::sample_type        key;
         int                         j;
         logic [smf_pkg::SAMPLE_W:0] pair_sum;
         window_hist[next_slot] = fresh;
         next_slot = (next_slot == smf_pkg::LAST_SLOT) ? '0 : next_slot + 1'b1;
         ordered = window_hist;
         for (int i = 1; i < smf_pkg::WINDOW; i++) begin
            key = ordered[i];
            j   = i - 1;
            while (j >= 0 && ordered[j] > key) begin
               ordered[j + 1] = ordered[j];
               j--;
            end
            ordered[j + 1] = key;
         end
         // Floor average of the two middle values.
         pair_sum = {1'b0, ordered[smf_pkg::MID_LO]} + {1'b0, ordered[smf_pkg::MID_HI]};
         expected_filtered.push_back(pair_sum[smf_pkg::SAMPLE_W:1]);
      endfunction

      task report(string msg);
         if (errors < MAX_PRINTED) $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_filtered(smf_pkg::sample_type got);
         smf_pkg::sample_type want;
         if (expected_filtered.size() == 0) begin
            report($sformatf("filtered %0d arrived with nothing expected", got));
         end else begin
            want = expected_filtered.pop_front();
            if (got != want)
               report($sformatf("filtered %0d, expected %0d", got, want));
         end
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   logic idle_on     = 1'b1;
   int   hold_count  = 0;
   int   hold_seen   = 0;
   int   hold_left   = 0;
   int   quiet_cycles = 0;
   int   adc_level   = 2048;

   median_scoreboard median_sb = new();

   sliding_median_filter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: checks accepted items, idles at random and runs the long
   // hold-off whenever the stimulus asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            median_sb.check_filtered(rsp_tdata[smf_pkg::SAMPLE_W-1:0]);
         if (hold_count != hold_seen) begin
            hold_seen = hold_count;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic send_sample(input logic [15:0] word);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      median_sb.take_sample(word[smf_pkg::SAMPLE_W-1:0]);
   endtask

   task automatic wait_for_results();
      while (median_sb.expected_filtered.size() != 0) @(posedge clock);
   endtask

   // Mostly a noisy level with occasional jumps, some rail spikes, and some
   // uniform values.
   function automatic smf_pkg::sample_type next_adc_sample();
      int pick;
      int value;
      pick = $urandom_range(99);
      if (pick < 5) adc_level = $urandom_range(4095);
      if (pick < 60)
         value = adc_level + int'($urandom_range(64)) - 32;
      else if (pick < 75)
         value = $urandom_range(1) ? 4095 - int'($urandom_range(3)) : int'($urandom_range(3));
      else
         value = $urandom_range(4095);
      if (value < 0) value = 0;
      if (value > 4095) value = 4095;
      return smf_pkg::sample_type'(value);
   endfunction

   initial begin
      logic [15:0] directed_words[19] = '{
         16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0000, 16'h0001,
         16'h0800, 16'h07FF, 16'h0AAA, 16'h0555, 16'h0FFE, 16'h0000, 16'h0000,
         16'hF123, 16'h8FFF, 16'h7000, 16'h0FFF, 16'h0001
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Start-up with zeros in the window, rails, floor rounding, and stray
      // bits above the sample field.
      foreach (directed_words[k]) send_sample(directed_words[k]);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 150) hold_count <= hold_count + 1;
         if (i == 500) idle_on <= 1'b0;
         if (i == 800) idle_on <= 1'b1;
         if (i == 1000) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            wait_for_results();
         end
         send_sample({4'h0, next_adc_sample()});
      end
      req_tvalid <= 1'b0;

      wait_for_results();
      repeat (4 * LATENCY) @(posedge clock);
      if (median_sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: sim.f
sv/smf_pkg.sv
sv/smf_sorter.sv
sv/sliding_median_filter_core.sv
test/testbench.sv
